// ----- rtl/ids_pkg.sv -----
// ---------------------------------------------------------------------------
// Intercom door unlock sequencer package
// Shared widths, codes and the event bundle passed from the step logic to
// the result serializer.
// ---------------------------------------------------------------------------
package ids_pkg;

   // Field widths
   localparam int LINE_W    = 10;
   localparam int CMD_W     = 3;
   localparam int TICKS_W   = 16;
   localparam int CODE_W    = 3;
   localparam int PHASE_W   = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Ring check runs once every RING_PERIOD ticks.
   localparam logic [PHASE_W-1:0] RING_PERIOD = PHASE_W'(100);

   // Most events one tick can raise: command, stage timer, ring check.
   localparam int MAX_EVENTS = 3;
   localparam int COUNT_W    = 2;

   // Reset values of the configuration registers
   localparam logic [LINE_W-1:0]  RING_THRESHOLD_RST = LINE_W'(512);
   localparam logic [TICKS_W-1:0] ANSWER_TICKS_RST   = TICKS_W'(1000);
   localparam logic [TICKS_W-1:0] HOLD_TICKS_RST     = TICKS_W'(2000);
   localparam logic [TICKS_W-1:0] AUTO_TICKS_RST     = TICKS_W'(3000);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RING_THRESHOLD = 2'd0,
      CSR_ANSWER_TICKS   = 2'd1,
      CSR_HOLD_TICKS     = 2'd2,
      CSR_AUTO_TICKS     = 2'd3
   } csr_index_type;

   // Remote commands; codes above CMD_AUTO_OFF are ignored.
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE     = 3'd0,
      CMD_UNLOCK   = 3'd1,
      CMD_HANGUP   = 3'd2,
      CMD_AUTO_ON  = 3'd3,
      CMD_AUTO_OFF = 3'd4
   } command_type;

   // Pending one-shot stage
   typedef enum logic [1:0] {
      ST_NONE   = 2'd0,
      ST_ANSWER = 2'd1,
      ST_UNLOCK = 2'd2,
      ST_HANGUP = 2'd3
   } stage_type;

   // Event codes reported on the result channel
   typedef enum logic [CODE_W-1:0] {
      EV_NONE       = 3'd0,
      EV_RING_START = 3'd1,
      EV_RING_END   = 3'd2,
      EV_UNLOCKED   = 3'd3,
      EV_AUTO_STATE = 3'd4
   } event_type;

   // All results of one tick
   typedef struct packed {
      logic [MAX_EVENTS-1:0][CODE_W-1:0] code;
      logic [MAX_EVENTS-1:0]             flag;
      logic [COUNT_W-1:0]                count;
      logic                              answer;
      logic                              unlock;
   } bundle_type;

endpackage

// ----- rtl/ids_core.sv -----
// ---------------------------------------------------------------------------
// Intercom sequencer step logic
// Holds the configuration and controller state and works out one tick
// combinationally: command, button edge, stage timer, then ring check.
// ---------------------------------------------------------------------------
module ids_core (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration writes
   input  logic                        csr_we,
   input  logic [ids_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ids_pkg::CSR_DATA_W-1:0] csr_data,
   // Tick to process
   input  logic                        step,
   input  logic [ids_pkg::LINE_W-1:0]  line_level,
   input  logic                        button_level,
   input  logic [ids_pkg::CMD_W-1:0]   command,
   output ids_pkg::bundle_type         bundle
);

   logic [ids_pkg::LINE_W-1:0]  ring_threshold_ff;
   logic [ids_pkg::TICKS_W-1:0] answer_ticks_ff;
   logic [ids_pkg::TICKS_W-1:0] hold_ticks_ff;
   logic [ids_pkg::TICKS_W-1:0] auto_ticks_ff;

   logic ringing_ff, ringing_in;
   logic unlocking_ff, unlocking_in;
   logic auto_ff, auto_in;
   logic prev_button_ff, prev_button_in;
   ids_pkg::stage_type stage_ff, stage_in;
   logic [ids_pkg::TICKS_W-1:0] countdown_ff, countdown_in;
   logic [ids_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic answer_ff, answer_in;
   logic unlock_ff, unlock_in;

   logic                                         fresh;
   ids_pkg::stage_type                           fired;
   logic [ids_pkg::PHASE_W-1:0]                  phase_next;
   logic [ids_pkg::COUNT_W-1:0]                  n;
   logic [ids_pkg::MAX_EVENTS-1:0][ids_pkg::CODE_W-1:0] codes;
   logic [ids_pkg::MAX_EVENTS-1:0]               flags;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_threshold_ff <= ids_pkg::RING_THRESHOLD_RST;
         answer_ticks_ff   <= ids_pkg::ANSWER_TICKS_RST;
         hold_ticks_ff     <= ids_pkg::HOLD_TICKS_RST;
         auto_ticks_ff     <= ids_pkg::AUTO_TICKS_RST;
      end else if (csr_we) begin
         unique case (ids_pkg::csr_index_type'(csr_index))
            ids_pkg::CSR_RING_THRESHOLD: ring_threshold_ff <= csr_data[ids_pkg::LINE_W-1:0];
            ids_pkg::CSR_ANSWER_TICKS:   answer_ticks_ff   <= csr_data;
            ids_pkg::CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_data;
            ids_pkg::CSR_AUTO_TICKS:     auto_ticks_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // One tick of the controller
   always_comb begin
      ringing_in     = ringing_ff;
      unlocking_in   = unlocking_ff;
      auto_in        = auto_ff;
      prev_button_in = prev_button_ff;
      stage_in       = stage_ff;
      countdown_in   = countdown_ff;
      answer_in      = answer_ff;
      unlock_in      = unlock_ff;
      fresh          = 1'b0;
      fired          = ids_pkg::ST_NONE;
      n              = '0;
      codes          = '0;
      flags          = '0;

      // Remote command
      unique case (command)
         ids_pkg::CMD_UNLOCK: begin
            unlocking_in = 1'b1;
            answer_in    = 1'b1;
            stage_in     = ids_pkg::ST_UNLOCK;
            countdown_in = answer_ticks_ff;
            fresh        = 1'b1;
         end
         ids_pkg::CMD_HANGUP: begin
            unlocking_in = 1'b0;
            answer_in    = 1'b0;
            unlock_in    = 1'b0;
            codes[n]     = ids_pkg::EV_UNLOCKED;
            flags[n]     = auto_in;
            n            = n + 1'b1;
            auto_in      = 1'b0;
         end
         ids_pkg::CMD_AUTO_ON: begin
            auto_in  = 1'b1;
            codes[n] = ids_pkg::EV_AUTO_STATE;
            flags[n] = 1'b1;
            n        = n + 1'b1;
         end
         ids_pkg::CMD_AUTO_OFF: begin
            auto_in  = 1'b0;
            codes[n] = ids_pkg::EV_AUTO_STATE;
            flags[n] = 1'b0;
            n        = n + 1'b1;
         end
         default: ;
      endcase

      // A button press (level going low) answers at once and arms the unlock stage.
      if (button_level != prev_button_in) begin
         if (!button_level) begin
            unlocking_in = 1'b1;
            answer_in    = 1'b1;
            stage_in     = ids_pkg::ST_UNLOCK;
            countdown_in = answer_ticks_ff;
            fresh        = 1'b1;
         end
         prev_button_in = button_level;
      end

      // Stage timer; a count of zero fires like one.
      if (stage_in != ids_pkg::ST_NONE && !fresh) begin
         if (countdown_in <= ids_pkg::TICKS_W'(1)) begin
            fired        = stage_in;
            stage_in     = ids_pkg::ST_NONE;
            countdown_in = '0;
         end else begin
            countdown_in = countdown_in - 1'b1;
         end
      end

      unique case (fired)
         ids_pkg::ST_ANSWER: begin
            unlocking_in = 1'b1;
            answer_in    = 1'b1;
            stage_in     = ids_pkg::ST_UNLOCK;
            countdown_in = answer_ticks_ff;
         end
         ids_pkg::ST_UNLOCK: begin
            unlock_in    = 1'b1;
            stage_in     = ids_pkg::ST_HANGUP;
            countdown_in = hold_ticks_ff;
         end
         ids_pkg::ST_HANGUP: begin
            unlocking_in = 1'b0;
            answer_in    = 1'b0;
            unlock_in    = 1'b0;
            codes[n]     = ids_pkg::EV_UNLOCKED;
            flags[n]     = auto_in;
            n            = n + 1'b1;
            auto_in      = 1'b0;
         end
         default: ;
      endcase

      // Ring check once per period, skipped while an unlock runs.
      phase_next = phase_ff + 1'b1;
      phase_in   = phase_next;
      if (phase_next >= ids_pkg::RING_PERIOD) begin
         phase_in = '0;
         if (!unlocking_in) begin
            if (line_level > ring_threshold_ff) begin
               if (!ringing_in) begin
                  ringing_in = 1'b1;
                  codes[n]   = ids_pkg::EV_RING_START;
                  flags[n]   = 1'b0;
                  n          = n + 1'b1;
                  if (auto_in) begin
                     stage_in     = ids_pkg::ST_ANSWER;
                     countdown_in = auto_ticks_ff;
                  end
               end
            end else if (ringing_in) begin
               ringing_in = 1'b0;
               codes[n]   = ids_pkg::EV_RING_END;
               flags[n]   = 1'b0;
               n          = n + 1'b1;
            end
         end
      end

      // A quiet tick still gives one result with no event.
      if (n == '0) begin
         n = ids_pkg::COUNT_W'(1);
      end

      bundle.code   = codes;
      bundle.flag   = flags;
      bundle.count  = n;
      bundle.answer = answer_in;
      bundle.unlock = unlock_in;
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         ringing_ff     <= 1'b0;
         unlocking_ff   <= 1'b0;
         auto_ff        <= 1'b0;
         prev_button_ff <= 1'b1;
         stage_ff       <= ids_pkg::ST_NONE;
         countdown_ff   <= '0;
         phase_ff       <= '0;
         answer_ff      <= 1'b0;
         unlock_ff      <= 1'b0;
      end else if (step) begin
         ringing_ff     <= ringing_in;
         unlocking_ff   <= unlocking_in;
         auto_ff        <= auto_in;
         prev_button_ff <= prev_button_in;
         stage_ff       <= stage_in;
         countdown_ff   <= countdown_in;
         phase_ff       <= phase_in;
         answer_ff      <= answer_in;
         unlock_ff      <= unlock_in;
      end
   end

endmodule

// ----- rtl/ids_emit.sv -----
// ---------------------------------------------------------------------------
// Intercom sequencer result serializer
// Holds the results of one tick and sends them out one beat at a time.
// ---------------------------------------------------------------------------
module ids_emit (
   input  logic                            clock,
   input  logic                            reset,
   // Bundle from the step logic
   input  logic                            load_valid,
   output logic                            load_ready,
   input  ids_pkg::bundle_type             load_bundle,
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ids_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);

   ids_pkg::bundle_type         bundle_ff;
   logic                        full_ff, full_in;
   logic [ids_pkg::COUNT_W-1:0] idx_ff, idx_in;
   logic                        pop;
   logic                        last;

   assign last       = (idx_ff == bundle_ff.count - 1'b1);
   assign pop        = full_ff && rsp_tready;
   assign load_ready = !full_ff || (pop && last);

   // Walk through the stored events; refill as the final one leaves.
   always_comb begin
      full_in = full_ff;
      idx_in  = idx_ff;
      if (pop) begin
         if (last) begin
            full_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load_valid && load_ready) begin
         full_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         full_ff <= full_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         bundle_ff <= load_bundle;
      end
   end

   // Output beat
   assign rsp_tvalid = full_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = {2'b00, bundle_ff.flag[idx_ff], bundle_ff.code[idx_ff],
                        bundle_ff.unlock, bundle_ff.answer};

endmodule

// ----- rtl/intercom_door_unlock_sequencer.sv -----
// ---------------------------------------------------------------------------
// Intercom door unlock sequencer
// Top level: input register, step logic and result serializer.
// ---------------------------------------------------------------------------
// One request beat is one 1 ms tick. A tick is registered, worked out
// combinationally by the step logic, and its results (one to three beats, the
// final one marked by rsp_tlast) are sent from the serializer one beat per
// cycle while rsp_tready is high. A new tick is taken only as the previous
// tick's final result leaves; the single result port sets that limit.
// Configuration writes are taken at any time and should be issued only while
// no tick is in flight.
module intercom_door_unlock_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // line_level [9:0], button_level [10], command [13:11], zero [15:14]
   input  logic [ids_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // answer_drive [0], unlock_drive [1], event_code [4:2], event_flag [5],
   // zero [7:6]
   output logic [ids_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   // Configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ids_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ids_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                           in_valid_ff;
   logic [ids_pkg::REQ_DATA_W-1:0] in_data_ff;
   logic                           load_ready;
   logic                           step;
   ids_pkg::bundle_type            bundle;

   assign csr_ready  = 1'b1;
   assign step       = in_valid_ff && load_ready;
   assign req_tready = !in_valid_ff || step;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   ids_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .step         (step),
      .line_level   (in_data_ff[9:0]),
      .button_level (in_data_ff[10]),
      .command      (in_data_ff[13:11]),
      .bundle       (bundle)
   );

   ids_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (in_valid_ff),
      .load_ready  (load_ready),
      .load_bundle (bundle),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
